### rtl/core/post_seq_pkg.sv
// Package for the power-on self-test sequencer: phase and event codes,
// transaction structs, config register indexes and lamp/tone constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package post_seq_pkg;

  localparam int ALARM_CHANNELS = 16;
  localparam int ALARM_W        = 16;
  localparam int DUTY_W         = 12;
  localparam int TIME_W         = 32;
  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 3;

  localparam logic [ALARM_W-1:0] CHANNEL_MASK =
    (ALARM_CHANNELS >= ALARM_W) ? {ALARM_W{1'b1}}
                                : ALARM_W'((64'd1 << ALARM_CHANNELS) - 64'd1);

  localparam logic [DUTY_W-1:0] DUTY_FULL = 12'd4095;
  localparam logic [DUTY_W-1:0] DUTY_OFF  = 12'd0;

  localparam logic [3:0] TONE_FILE_LO  = 4'd13;
  localparam logic [3:0] TONE_FILE_MID = 4'd14;
  localparam logic [3:0] TONE_FILE_HI  = 4'd15;

  localparam logic [CFG_W-1:0] RST_COLOR_STEP  = 16'd500;
  localparam logic [CFG_W-1:0] RST_WHITE_STEP  = 16'd400;
  localparam logic [CFG_W-1:0] RST_FAULT_HALF  = 16'd125;
  localparam logic [CFG_W-1:0] RST_FAULT_DUR   = 16'd3000;
  localparam logic [CFG_W-1:0] RST_CARD_HALF   = 16'd100;
  localparam logic [CFG_W-1:0] RST_CARD_DUR    = 16'd5000;
  localparam logic [CFG_W-1:0] RST_ACK_HALF    = 16'd250;
  localparam logic [CFG_W-1:0] RST_IGNORE_MASK = 16'd0;

  typedef enum logic [3:0] {
    PH_RED      = 4'd0,
    PH_GREEN    = 4'd1,
    PH_BLUE     = 4'd2,
    PH_WHITE    = 4'd3,
    PH_FAULT    = 4'd4,
    PH_TONE_LO  = 4'd5,
    PH_TONE_MID = 4'd6,
    PH_TONE_HI  = 4'd7,
    PH_CARD     = 4'd8,
    PH_ACK      = 4'd9,
    PH_DONE     = 4'd10
  } phase_t;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_TICK   = 2'd1,
    OP_BUTTON = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_STEP  = 3'd0,
    CFG_WHITE_STEP  = 3'd1,
    CFG_FAULT_HALF  = 3'd2,
    CFG_FAULT_DUR   = 3'd3,
    CFG_CARD_HALF   = 3'd4,
    CFG_CARD_DUR    = 3'd5,
    CFG_ACK_HALF    = 3'd6,
    CFG_IGNORE_MASK = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [TIME_W-1:0]  now_ms;
    logic               card_ok;
    logic [ALARM_W-1:0] alarm_bits;
    logic               audio_busy;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] red_duty;
    logic [DUTY_W-1:0] green_duty;
    logic [DUTY_W-1:0] blue_duty;
    logic              play_request;
    logic [3:0]        tone_file;
    logic              active;
    logic [3:0]        phase;
  } out_t;

endpackage

`default_nettype wire

### rtl/core/power_on_self_test_sequencer.sv
// Top level of the power-on self-test sequencer: event decode, phase FSM,
// flash timers, config registers and the result register.
// Depends on post_seq_pkg.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_stall   | in_data  (post_seq_pkg::in_t)
//   out     | output    | out_valid / out_stall | out_data (post_seq_pkg::out_t)
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One event per cycle while in_stall is low; its result is valid on the cycle after acceptance.
// Latency is one register stage: phase, timers and lamp duties update at accept.
// in_stall rises only while a result is held and out_stall is high.
// rst is synchronous; after it the block is inactive (phase done) and the
// config registers hold their default values. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module power_on_self_test_sequencer (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire post_seq_pkg::in_t                    in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output post_seq_pkg::out_t                        out_data,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [post_seq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [post_seq_pkg::CFG_W-1:0]       cfg_data
);

  logic [post_seq_pkg::CFG_W-1:0] color_step_ms;
  logic [post_seq_pkg::CFG_W-1:0] white_hold_ms;
  logic [post_seq_pkg::CFG_W-1:0] fault_flash_half_ms;
  logic [post_seq_pkg::CFG_W-1:0] fault_duration_ms;
  logic [post_seq_pkg::CFG_W-1:0] card_flash_half_ms;
  logic [post_seq_pkg::CFG_W-1:0] card_duration_ms;
  logic [post_seq_pkg::CFG_W-1:0] ack_flash_half_ms;
  logic [post_seq_pkg::CFG_W-1:0] ignore_mask;

  post_seq_pkg::phase_t                phase, phase_next;
  logic [post_seq_pkg::TIME_W-1:0]     phase_start, phase_start_next;
  logic [post_seq_pkg::TIME_W-1:0]     last_toggle, last_toggle_next;
  logic                                flash_lit, flash_lit_next;
  logic                                card_present, card_present_next;
  logic [post_seq_pkg::DUTY_W-1:0]     red, red_next;
  logic [post_seq_pkg::DUTY_W-1:0]     green, green_next;
  logic [post_seq_pkg::DUTY_W-1:0]     blue, blue_next;
  logic                                play, play_next;
  logic [3:0]                          tone, tone_next;

  logic                                accept;
  logic [post_seq_pkg::TIME_W-1:0]     now;
  logic [post_seq_pkg::TIME_W-1:0]     since;
  logic [post_seq_pkg::TIME_W-1:0]     toggle_gap;
  logic                                alarm_seen;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;

  assign now        = in_data.now_ms;
  assign since      = now - phase_start;
  assign toggle_gap = now - last_toggle;
  assign alarm_seen = |(in_data.alarm_bits & ~ignore_mask & post_seq_pkg::CHANNEL_MASK);

  always_ff @(posedge clk) begin
    if (rst) begin
      color_step_ms       <= post_seq_pkg::RST_COLOR_STEP;
      white_hold_ms       <= post_seq_pkg::RST_WHITE_STEP;
      fault_flash_half_ms <= post_seq_pkg::RST_FAULT_HALF;
      fault_duration_ms   <= post_seq_pkg::RST_FAULT_DUR;
      card_flash_half_ms  <= post_seq_pkg::RST_CARD_HALF;
      card_duration_ms    <= post_seq_pkg::RST_CARD_DUR;
      ack_flash_half_ms   <= post_seq_pkg::RST_ACK_HALF;
      ignore_mask         <= post_seq_pkg::RST_IGNORE_MASK;
    end else if (cfg_valid && cfg_ready) begin
      unique case (post_seq_pkg::cfg_reg_t'(cfg_index))
        post_seq_pkg::CFG_COLOR_STEP:  color_step_ms       <= cfg_data;
        post_seq_pkg::CFG_WHITE_STEP:  white_hold_ms       <= cfg_data;
        post_seq_pkg::CFG_FAULT_HALF:  fault_flash_half_ms <= cfg_data;
        post_seq_pkg::CFG_FAULT_DUR:   fault_duration_ms   <= cfg_data;
        post_seq_pkg::CFG_CARD_HALF:   card_flash_half_ms  <= cfg_data;
        post_seq_pkg::CFG_CARD_DUR:    card_duration_ms    <= cfg_data;
        post_seq_pkg::CFG_ACK_HALF:    ack_flash_half_ms   <= cfg_data;
        post_seq_pkg::CFG_IGNORE_MASK: ignore_mask         <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= post_seq_pkg::PH_DONE;
      phase_start  <= '0;
      last_toggle  <= '0;
      flash_lit    <= 1'b0;
      card_present <= 1'b0;
      red          <= '0;
      green        <= '0;
      blue         <= '0;
      play         <= 1'b0;
      tone         <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        phase_start  <= phase_start_next;
        last_toggle  <= last_toggle_next;
        flash_lit    <= flash_lit_next;
        card_present <= card_present_next;
        red          <= red_next;
        green        <= green_next;
        blue         <= blue_next;
        play         <= play_next;
        tone         <= tone_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid    <= 1'b0;
      end
    end
  end

  always_comb begin
    phase_next        = phase;
    phase_start_next  = phase_start;
    last_toggle_next  = last_toggle;
    flash_lit_next    = flash_lit;
    card_present_next = card_present;
    red_next          = red;
    green_next        = green;
    blue_next         = blue;
    play_next         = 1'b0;
    tone_next         = '0;

    unique case (post_seq_pkg::op_t'(in_data.operation))
      post_seq_pkg::OP_START: begin
        flash_lit_next    = 1'b0;
        last_toggle_next  = '0;
        card_present_next = in_data.card_ok;
        phase_next        = post_seq_pkg::PH_RED;
        phase_start_next  = now;
        red_next          = post_seq_pkg::DUTY_FULL;
        green_next        = post_seq_pkg::DUTY_OFF;
        blue_next         = post_seq_pkg::DUTY_OFF;
      end
      post_seq_pkg::OP_TICK: begin
        unique case (phase) inside
          post_seq_pkg::PH_RED, post_seq_pkg::PH_GREEN, post_seq_pkg::PH_BLUE: begin
            if (since >= post_seq_pkg::TIME_W'(color_step_ms)) begin
              phase_start_next = now;
              if (phase == post_seq_pkg::PH_RED) begin
                phase_next = post_seq_pkg::PH_GREEN;
                red_next   = post_seq_pkg::DUTY_OFF;
                green_next = post_seq_pkg::DUTY_FULL;
                blue_next  = post_seq_pkg::DUTY_OFF;
              end else if (phase == post_seq_pkg::PH_GREEN) begin
                phase_next = post_seq_pkg::PH_BLUE;
                red_next   = post_seq_pkg::DUTY_OFF;
                green_next = post_seq_pkg::DUTY_OFF;
                blue_next  = post_seq_pkg::DUTY_FULL;
              end else begin
                phase_next = post_seq_pkg::PH_WHITE;
                red_next   = post_seq_pkg::DUTY_FULL;
                green_next = post_seq_pkg::DUTY_FULL;
                blue_next  = post_seq_pkg::DUTY_FULL;
              end
            end
          end
          post_seq_pkg::PH_WHITE: begin
            if (since >= post_seq_pkg::TIME_W'(white_hold_ms)) begin
              if (alarm_seen) begin
                phase_next       = post_seq_pkg::PH_FAULT;
                flash_lit_next   = 1'b1;
                last_toggle_next = now;
                phase_start_next = now;
                red_next         = post_seq_pkg::DUTY_OFF;
                green_next       = post_seq_pkg::DUTY_OFF;
                blue_next        = post_seq_pkg::DUTY_FULL;
              end else if (!card_present) begin
                phase_next       = post_seq_pkg::PH_CARD;
                flash_lit_next   = 1'b1;
                last_toggle_next = now;
                phase_start_next = now;
                red_next         = post_seq_pkg::DUTY_FULL;
                green_next       = post_seq_pkg::DUTY_OFF;
                blue_next        = post_seq_pkg::DUTY_OFF;
              end else begin
                phase_next = post_seq_pkg::PH_TONE_LO;
                red_next   = post_seq_pkg::DUTY_OFF;
                green_next = post_seq_pkg::DUTY_OFF;
                blue_next  = post_seq_pkg::DUTY_OFF;
                play_next  = 1'b1;
                tone_next  = post_seq_pkg::TONE_FILE_LO;
              end
            end
          end
          post_seq_pkg::PH_FAULT: begin
            if (toggle_gap >= post_seq_pkg::TIME_W'(fault_flash_half_ms)) begin
              flash_lit_next   = ~flash_lit;
              last_toggle_next = now;
              blue_next        = flash_lit ? post_seq_pkg::DUTY_OFF : post_seq_pkg::DUTY_FULL;
            end
            if (since >= post_seq_pkg::TIME_W'(fault_duration_ms)) begin
              if (card_present) begin
                phase_next = post_seq_pkg::PH_TONE_LO;
                red_next   = post_seq_pkg::DUTY_OFF;
                green_next = post_seq_pkg::DUTY_OFF;
                blue_next  = post_seq_pkg::DUTY_OFF;
                play_next  = 1'b1;
                tone_next  = post_seq_pkg::TONE_FILE_LO;
              end else begin
                phase_next       = post_seq_pkg::PH_CARD;
                flash_lit_next   = 1'b1;
                last_toggle_next = now;
                phase_start_next = now;
                red_next         = post_seq_pkg::DUTY_FULL;
                green_next       = post_seq_pkg::DUTY_OFF;
                blue_next        = post_seq_pkg::DUTY_OFF;
              end
            end
          end
          post_seq_pkg::PH_TONE_LO: begin
            if (!in_data.audio_busy) begin
              phase_next = post_seq_pkg::PH_TONE_MID;
              play_next  = 1'b1;
              tone_next  = post_seq_pkg::TONE_FILE_MID;
            end
          end
          post_seq_pkg::PH_TONE_MID: begin
            if (!in_data.audio_busy) begin
              phase_next = post_seq_pkg::PH_TONE_HI;
              play_next  = 1'b1;
              tone_next  = post_seq_pkg::TONE_FILE_HI;
            end
          end
          post_seq_pkg::PH_TONE_HI: begin
            if (!in_data.audio_busy) begin
              phase_next       = post_seq_pkg::PH_ACK;
              flash_lit_next   = 1'b1;
              last_toggle_next = now;
              red_next         = post_seq_pkg::DUTY_OFF;
              green_next       = post_seq_pkg::DUTY_FULL;
              blue_next        = post_seq_pkg::DUTY_OFF;
            end
          end
          post_seq_pkg::PH_CARD: begin
            if (toggle_gap >= post_seq_pkg::TIME_W'(card_flash_half_ms)) begin
              flash_lit_next   = ~flash_lit;
              last_toggle_next = now;
              red_next         = flash_lit ? post_seq_pkg::DUTY_OFF : post_seq_pkg::DUTY_FULL;
            end
            if (since >= post_seq_pkg::TIME_W'(card_duration_ms)) begin
              phase_next       = post_seq_pkg::PH_ACK;
              flash_lit_next   = 1'b1;
              last_toggle_next = now;
              red_next         = post_seq_pkg::DUTY_OFF;
              green_next       = post_seq_pkg::DUTY_FULL;
              blue_next        = post_seq_pkg::DUTY_OFF;
            end
          end
          post_seq_pkg::PH_ACK: begin
            if (toggle_gap >= post_seq_pkg::TIME_W'(ack_flash_half_ms)) begin
              flash_lit_next   = ~flash_lit;
              last_toggle_next = now;
              green_next       = flash_lit ? post_seq_pkg::DUTY_OFF : post_seq_pkg::DUTY_FULL;
            end
          end
          default: ;
        endcase
      end
      post_seq_pkg::OP_BUTTON: begin
        if (phase == post_seq_pkg::PH_ACK) begin
          phase_next = post_seq_pkg::PH_DONE;
          red_next   = post_seq_pkg::DUTY_OFF;
          green_next = post_seq_pkg::DUTY_OFF;
          blue_next  = post_seq_pkg::DUTY_OFF;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_data.red_duty     = red;
    out_data.green_duty   = green;
    out_data.blue_duty    = blue;
    out_data.play_request = play;
    out_data.tone_file    = tone;
    out_data.active       = (phase != post_seq_pkg::PH_DONE);
    out_data.phase        = phase;
  end

  a_play_in_tone: assert property (@(posedge clk) disable iff (rst)
    play |-> (phase == post_seq_pkg::PH_TONE_LO || phase == post_seq_pkg::PH_TONE_MID ||
              phase == post_seq_pkg::PH_TONE_HI))
    else $error("tone request outside a tone phase");

  a_tone_file: assert property (@(posedge clk) disable iff (rst)
    play |-> (tone == post_seq_pkg::TONE_FILE_LO || tone == post_seq_pkg::TONE_FILE_MID ||
              tone == post_seq_pkg::TONE_FILE_HI))
    else $error("tone request with bad file number");

  a_done_dark: assert property (@(posedge clk) disable iff (rst)
    (phase == post_seq_pkg::PH_DONE) |-> (red == '0 && green == '0 && blue == '0))
    else $error("lamp lit while sequence is done");

  a_ack_green_only: assert property (@(posedge clk) disable iff (rst)
    (phase == post_seq_pkg::PH_ACK) |-> (red == '0 && blue == '0))
    else $error("red or blue lit during acknowledge wait");

  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.operation == post_seq_pkg::OP_START) |=>
      (phase == post_seq_pkg::PH_RED && out_valid && red == post_seq_pkg::DUTY_FULL))
    else $error("start did not restart at red");

endmodule

`default_nettype wire

### tb/testbench.sv
// Testbench for power_on_self_test_sequencer: directed and random event streams,
// each result checked against an in-bench model of the self-test phase sequence.
// Depends on post_seq_pkg and the sequencer RTL.
`timescale 1ns / 1ps
module testbench;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 600000;
  localparam int         HOLD_CYCLES = 150;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  post_seq_pkg::in_t                  in_data = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  post_seq_pkg::out_t                 out_data;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [post_seq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [post_seq_pkg::CFG_W-1:0]     cfg_data = '0;

  power_on_self_test_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  logic [post_seq_pkg::CFG_W-1:0]  cfg_shadow [8];
  logic [post_seq_pkg::CFG_W-1:0]  cfg_next [8];
  post_seq_pkg::phase_t            seq_phase;
  logic [post_seq_pkg::TIME_W-1:0] phase_origin;
  logic [post_seq_pkg::TIME_W-1:0] toggle_origin;
  logic                            lamp_lit;
  logic                            card_seen;
  logic [post_seq_pkg::DUTY_W-1:0] duty [3];
  logic                            tone_req;
  logic [3:0]                      tone_num;

  post_seq_pkg::out_t expected_results [$];
  int   failures   = 0;
  int   cycles     = 0;
  int   items_sent = 0;
  bit   gaps_on    = 1'b1;
  bit   stalls_on  = 1'b1;
  bit   hold_req   = 1'b0;

  task automatic reset_model();
    cfg_shadow[post_seq_pkg::CFG_COLOR_STEP]  = post_seq_pkg::RST_COLOR_STEP;
    cfg_shadow[post_seq_pkg::CFG_WHITE_STEP]  = post_seq_pkg::RST_WHITE_STEP;
    cfg_shadow[post_seq_pkg::CFG_FAULT_HALF]  = post_seq_pkg::RST_FAULT_HALF;
    cfg_shadow[post_seq_pkg::CFG_FAULT_DUR]   = post_seq_pkg::RST_FAULT_DUR;
    cfg_shadow[post_seq_pkg::CFG_CARD_HALF]   = post_seq_pkg::RST_CARD_HALF;
    cfg_shadow[post_seq_pkg::CFG_CARD_DUR]    = post_seq_pkg::RST_CARD_DUR;
    cfg_shadow[post_seq_pkg::CFG_ACK_HALF]    = post_seq_pkg::RST_ACK_HALF;
    cfg_shadow[post_seq_pkg::CFG_IGNORE_MASK] = post_seq_pkg::RST_IGNORE_MASK;
    seq_phase     = post_seq_pkg::PH_DONE;
    phase_origin  = '0;
    toggle_origin = '0;
    lamp_lit      = 1'b0;
    card_seen     = 1'b0;
    duty[0] = post_seq_pkg::DUTY_OFF;
    duty[1] = post_seq_pkg::DUTY_OFF;
    duty[2] = post_seq_pkg::DUTY_OFF;
  endtask

  task automatic set_duties(logic [post_seq_pkg::DUTY_W-1:0] r,
                            logic [post_seq_pkg::DUTY_W-1:0] g,
                            logic [post_seq_pkg::DUTY_W-1:0] b);
    duty[0] = r;
    duty[1] = g;
    duty[2] = b;
  endtask

  task automatic enter_phase(post_seq_pkg::phase_t ph, logic [post_seq_pkg::TIME_W-1:0] now);
    seq_phase = ph;
    case (ph)
      post_seq_pkg::PH_RED: begin
        set_duties(post_seq_pkg::DUTY_FULL, post_seq_pkg::DUTY_OFF, post_seq_pkg::DUTY_OFF);
        phase_origin = now;
      end
      post_seq_pkg::PH_GREEN: begin
        set_duties(post_seq_pkg::DUTY_OFF, post_seq_pkg::DUTY_FULL, post_seq_pkg::DUTY_OFF);
        phase_origin = now;
      end
      post_seq_pkg::PH_BLUE: begin
        set_duties(post_seq_pkg::DUTY_OFF, post_seq_pkg::DUTY_OFF, post_seq_pkg::DUTY_FULL);
        phase_origin = now;
      end
      post_seq_pkg::PH_WHITE: begin
        set_duties(post_seq_pkg::DUTY_FULL, post_seq_pkg::DUTY_FULL, post_seq_pkg::DUTY_FULL);
        phase_origin = now;
      end
      post_seq_pkg::PH_FAULT: begin
        lamp_lit = 1'b1;
        toggle_origin = now;
        phase_origin = now;
        set_duties(post_seq_pkg::DUTY_OFF, post_seq_pkg::DUTY_OFF, post_seq_pkg::DUTY_FULL);
      end
      post_seq_pkg::PH_TONE_LO: begin
        set_duties(post_seq_pkg::DUTY_OFF, post_seq_pkg::DUTY_OFF, post_seq_pkg::DUTY_OFF);
        tone_req = 1'b1;
        tone_num = post_seq_pkg::TONE_FILE_LO;
      end
      post_seq_pkg::PH_TONE_MID: begin
        tone_req = 1'b1;
        tone_num = post_seq_pkg::TONE_FILE_MID;
      end
      post_seq_pkg::PH_TONE_HI: begin
        tone_req = 1'b1;
        tone_num = post_seq_pkg::TONE_FILE_HI;
      end
      post_seq_pkg::PH_CARD: begin
        lamp_lit = 1'b1;
        toggle_origin = now;
        phase_origin = now;
        set_duties(post_seq_pkg::DUTY_FULL, post_seq_pkg::DUTY_OFF, post_seq_pkg::DUTY_OFF);
      end
      post_seq_pkg::PH_ACK: begin
        lamp_lit = 1'b1;
        toggle_origin = now;
        set_duties(post_seq_pkg::DUTY_OFF, post_seq_pkg::DUTY_FULL, post_seq_pkg::DUTY_OFF);
      end
      default: begin
        set_duties(post_seq_pkg::DUTY_OFF, post_seq_pkg::DUTY_OFF, post_seq_pkg::DUTY_OFF);
        seq_phase = post_seq_pkg::PH_DONE;
      end
    endcase
  endtask

  task automatic flash_update(logic [post_seq_pkg::TIME_W-1:0] now,
                              logic [post_seq_pkg::CFG_W-1:0] half, logic [1:0] lamp);
    logic [post_seq_pkg::TIME_W-1:0] elapsed;
    elapsed = now - toggle_origin;
    if (elapsed >= post_seq_pkg::TIME_W'(half)) begin
      lamp_lit = !lamp_lit;
      toggle_origin = now;
      duty[lamp] = lamp_lit ? post_seq_pkg::DUTY_FULL : post_seq_pkg::DUTY_OFF;
    end
  endtask

  function automatic logic [post_seq_pkg::TIME_W-1:0] cfg_time(post_seq_pkg::cfg_reg_t idx);
    return post_seq_pkg::TIME_W'(cfg_shadow[idx]);
  endfunction

  task automatic advance_sequence(input post_seq_pkg::in_t ev, output post_seq_pkg::out_t res);
    logic [post_seq_pkg::TIME_W-1:0] since;
    logic                            alarm_hit;
    tone_req = 1'b0;
    tone_num = 4'd0;
    since = ev.now_ms - phase_origin;
    alarm_hit = (ev.alarm_bits & ~cfg_shadow[post_seq_pkg::CFG_IGNORE_MASK] &
                 post_seq_pkg::CHANNEL_MASK) != '0;
    case (ev.operation)
      post_seq_pkg::OP_START: begin
        lamp_lit = 1'b0;
        toggle_origin = '0;
        card_seen = ev.card_ok;
        enter_phase(post_seq_pkg::PH_RED, ev.now_ms);
      end
      post_seq_pkg::OP_TICK: begin
        case (seq_phase)
          post_seq_pkg::PH_RED:
            if (since >= cfg_time(post_seq_pkg::CFG_COLOR_STEP))
              enter_phase(post_seq_pkg::PH_GREEN, ev.now_ms);
          post_seq_pkg::PH_GREEN:
            if (since >= cfg_time(post_seq_pkg::CFG_COLOR_STEP))
              enter_phase(post_seq_pkg::PH_BLUE, ev.now_ms);
          post_seq_pkg::PH_BLUE:
            if (since >= cfg_time(post_seq_pkg::CFG_COLOR_STEP))
              enter_phase(post_seq_pkg::PH_WHITE, ev.now_ms);
          post_seq_pkg::PH_WHITE:
            if (since >= cfg_time(post_seq_pkg::CFG_WHITE_STEP)) begin
              if (alarm_hit) enter_phase(post_seq_pkg::PH_FAULT, ev.now_ms);
              else if (!card_seen) enter_phase(post_seq_pkg::PH_CARD, ev.now_ms);
              else enter_phase(post_seq_pkg::PH_TONE_LO, ev.now_ms);
            end
          post_seq_pkg::PH_FAULT: begin
            flash_update(ev.now_ms, cfg_shadow[post_seq_pkg::CFG_FAULT_HALF], 2'd2);
            if (since >= cfg_time(post_seq_pkg::CFG_FAULT_DUR))
              enter_phase(card_seen ? post_seq_pkg::PH_TONE_LO : post_seq_pkg::PH_CARD,
                          ev.now_ms);
          end
          post_seq_pkg::PH_TONE_LO:
            if (!ev.audio_busy) enter_phase(post_seq_pkg::PH_TONE_MID, ev.now_ms);
          post_seq_pkg::PH_TONE_MID:
            if (!ev.audio_busy) enter_phase(post_seq_pkg::PH_TONE_HI, ev.now_ms);
          post_seq_pkg::PH_TONE_HI:
            if (!ev.audio_busy) enter_phase(post_seq_pkg::PH_ACK, ev.now_ms);
          post_seq_pkg::PH_CARD: begin
            flash_update(ev.now_ms, cfg_shadow[post_seq_pkg::CFG_CARD_HALF], 2'd0);
            if (since >= cfg_time(post_seq_pkg::CFG_CARD_DUR))
              enter_phase(post_seq_pkg::PH_ACK, ev.now_ms);
          end
          post_seq_pkg::PH_ACK:
            flash_update(ev.now_ms, cfg_shadow[post_seq_pkg::CFG_ACK_HALF], 2'd1);
          default: ;
        endcase
      end
      post_seq_pkg::OP_BUTTON:
        if (seq_phase == post_seq_pkg::PH_ACK) enter_phase(post_seq_pkg::PH_DONE, ev.now_ms);
      default: ;
    endcase
    res.red_duty     = duty[0];
    res.green_duty   = duty[1];
    res.blue_duty    = duty[2];
    res.play_request = tone_req;
    res.tone_file    = tone_num;
    res.active       = (seq_phase != post_seq_pkg::PH_DONE);
    res.phase        = seq_phase;
  endtask

  always @(posedge clk) begin : result_check
    post_seq_pkg::out_t want;
    post_seq_pkg::out_t pred;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no transaction pending: %h", out_data);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.red_duty !== want.red_duty) begin
            $error("red_duty expected %0d got %0d", want.red_duty, out_data.red_duty);
            failures++;
          end
          if (out_data.green_duty !== want.green_duty) begin
            $error("green_duty expected %0d got %0d", want.green_duty, out_data.green_duty);
            failures++;
          end
          if (out_data.blue_duty !== want.blue_duty) begin
            $error("blue_duty expected %0d got %0d", want.blue_duty, out_data.blue_duty);
            failures++;
          end
          if (out_data.play_request !== want.play_request) begin
            $error("play_request expected %0d got %0d", want.play_request,
                   out_data.play_request);
            failures++;
          end
          if (out_data.tone_file !== want.tone_file) begin
            $error("tone_file expected %0d got %0d", want.tone_file, out_data.tone_file);
            failures++;
          end
          if (out_data.active !== want.active) begin
            $error("active expected %0d got %0d", want.active, out_data.active);
            failures++;
          end
          if (out_data.phase !== want.phase) begin
            $error("phase expected %0d got %0d", want.phase, out_data.phase);
            failures++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        advance_sequence(in_data, pred);
        expected_results.push_back(pred);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin : receiver
    int stall_run;
    stall_run = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_stall = 1'b0;
      end else if (stall_run > 0) begin
        out_stall = 1'b1;
        stall_run--;
      end else if (stalls_on && $urandom_range(0, 99) < 25) begin
        out_stall = 1'b1;
        stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic post_seq_pkg::in_t make_event(logic [1:0] op,
                                                   logic [post_seq_pkg::TIME_W-1:0] now,
                                                   logic card,
                                                   logic [post_seq_pkg::ALARM_W-1:0] alarms,
                                                   logic busy);
    post_seq_pkg::in_t ev;
    ev.operation  = op;
    ev.now_ms     = now;
    ev.card_ok    = card;
    ev.alarm_bits = alarms;
    ev.audio_busy = busy;
    return ev;
  endfunction

  function automatic logic [post_seq_pkg::ALARM_W-1:0] rand_alarms();
    return post_seq_pkg::ALARM_W'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Enter and leave at a falling edge; valid stays up for a back-to-back transaction.
  task automatic send_event(post_seq_pkg::in_t ev);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = ev;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic quiesce();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic program_registers();
    quiesce();
    for (int i = 0; i < 8; i++) begin
      cfg_index = post_seq_pkg::cfg_reg_t'(i);
      cfg_data = cfg_next[i];
      cfg_valid = 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      cfg_shadow[cfg_index] = cfg_data;
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  function automatic logic [post_seq_pkg::TIME_W-1:0] pick_step();
    logic [post_seq_pkg::TIME_W-1:0] d;
    case (seq_phase)
      post_seq_pkg::PH_RED, post_seq_pkg::PH_GREEN, post_seq_pkg::PH_BLUE:
        d = cfg_time(post_seq_pkg::CFG_COLOR_STEP);
      post_seq_pkg::PH_WHITE: d = cfg_time(post_seq_pkg::CFG_WHITE_STEP);
      post_seq_pkg::PH_FAULT:
        d = $urandom_range(0, 1) ? cfg_time(post_seq_pkg::CFG_FAULT_HALF)
                                 : cfg_time(post_seq_pkg::CFG_FAULT_DUR);
      post_seq_pkg::PH_CARD:
        d = $urandom_range(0, 1) ? cfg_time(post_seq_pkg::CFG_CARD_HALF)
                                 : cfg_time(post_seq_pkg::CFG_CARD_DUR);
      post_seq_pkg::PH_ACK: d = cfg_time(post_seq_pkg::CFG_ACK_HALF);
      default:  d = 32'd8;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: return d;
      3:       return (d == 0) ? d : d - 32'd1;
      4, 5:    return $urandom_range(0, d);
      6:       return $urandom;
      default: return d + $urandom_range(0, 3);
    endcase
  endfunction

  function automatic logic [post_seq_pkg::ALARM_W-1:0] pick_alarms();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return rand_alarms();
      2:       return post_seq_pkg::ALARM_W'(1) << $urandom_range(0, post_seq_pkg::ALARM_W - 1);
      default: return cfg_shadow[post_seq_pkg::CFG_IGNORE_MASK];
    endcase
  endfunction

  task automatic run_sequences(int budget);
    int                              stop_at;
    int                              steps;
    logic [post_seq_pkg::TIME_W-1:0] t;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      t = $urandom;
      send_event(make_event(post_seq_pkg::OP_START, t, $urandom_range(0, 3) != 0,
                            rand_alarms(), rand_bit()));
      steps = 0;
      while (seq_phase != post_seq_pkg::PH_DONE && steps < 60 && items_sent < stop_at) begin
        steps++;
        if ($urandom_range(0, 99) < 8) begin
          send_event(make_event(2'($urandom_range(0, 3)),
                                $urandom_range(0, 1) ? t : post_seq_pkg::TIME_W'($urandom),
                                rand_bit(), rand_alarms(), rand_bit()));
        end else if (seq_phase == post_seq_pkg::PH_ACK && $urandom_range(0, 2) == 0) begin
          send_event(make_event(post_seq_pkg::OP_BUTTON, t, rand_bit(), rand_alarms(),
                                rand_bit()));
        end else begin
          t = t + pick_step();
          send_event(make_event(post_seq_pkg::OP_TICK, t, rand_bit(), pick_alarms(),
                                $urandom_range(0, 9) < 4));
        end
      end
    end
  endtask

  task automatic test_directed_events();
    logic [post_seq_pkg::TIME_W-1:0] t;
    send_event(make_event(post_seq_pkg::OP_TICK, 32'd0, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(post_seq_pkg::OP_BUTTON, 32'd5, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b1));
    t = 32'hFFFF_FF00;
    send_event(make_event(post_seq_pkg::OP_START, t, 1'b1, 16'h0000, 1'b0));
    send_event(make_event(post_seq_pkg::OP_TICK, t + 32'd499, 1'b0, 16'h0000, 1'b0));
    t = t + 32'd500;
    send_event(make_event(post_seq_pkg::OP_TICK, t, 1'b0, 16'h0000, 1'b0));
    t = t + 32'd500;
    send_event(make_event(post_seq_pkg::OP_TICK, t, 1'b0, 16'h0000, 1'b0));
    t = t + 32'd500;
    send_event(make_event(post_seq_pkg::OP_TICK, t, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(post_seq_pkg::OP_TICK, t + 32'd399, 1'b0, 16'hFFFF, 1'b0));
    t = t + 32'd400;
    send_event(make_event(post_seq_pkg::OP_TICK, t, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(post_seq_pkg::OP_TICK, t, 1'b0, 16'h0000, 1'b1));
    send_event(make_event(post_seq_pkg::OP_BUTTON, t, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(post_seq_pkg::OP_TICK, t, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(post_seq_pkg::OP_TICK, t, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(post_seq_pkg::OP_TICK, t, 1'b0, 16'h0000, 1'b0));
    t = t + 32'd250;
    send_event(make_event(post_seq_pkg::OP_TICK, t, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(post_seq_pkg::OP_TICK, t + 32'd249, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(post_seq_pkg::OP_BUTTON, t, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(post_seq_pkg::OP_TICK, t + 32'd1000, 1'b0, 16'h0000, 1'b0));
    t = 32'h7FFF_FFF0;
    send_event(make_event(post_seq_pkg::OP_START, t, 1'b0, 16'hFFFF, 1'b1));
    for (int i = 0; i < 3; i++) begin
      t = t + 32'd500;
      send_event(make_event(post_seq_pkg::OP_TICK, t, 1'b0, 16'h0000, 1'b0));
    end
    t = t + 32'd400;
    send_event(make_event(post_seq_pkg::OP_TICK, t, 1'b1, 16'hFFFF, 1'b1));
    t = t + 32'd125;
    send_event(make_event(post_seq_pkg::OP_TICK, t, 1'b0, 16'h8000, 1'b0));
    t = t + 32'd3000;
    send_event(make_event(post_seq_pkg::OP_TICK, t, 1'b0, 16'h0000, 1'b0));
    t = t + 32'd5000;
    send_event(make_event(post_seq_pkg::OP_TICK, t, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(post_seq_pkg::OP_START, t, 1'b1, 16'h0001, 1'b0));
  endtask

  task automatic test_backpressure();
    quiesce();
    gaps_on = 1'b0;
    hold_req = 1'b1;
    run_sequences(30);
    gaps_on = 1'b1;
  endtask

  task automatic test_register_extremes();
    for (int i = 0; i < 8; i++) cfg_next[i] = '0;
    program_registers();
    run_sequences(60);
    for (int i = 0; i < 8; i++) cfg_next[i] = '1;
    program_registers();
    run_sequences(60);
  endtask

  task automatic test_random_settings();
    for (int i = 0; i < 7; i++) cfg_next[i] = post_seq_pkg::CFG_W'($urandom_range(1, 30));
    cfg_next[post_seq_pkg::CFG_IGNORE_MASK] = post_seq_pkg::CFG_W'($urandom);
    program_registers();
    run_sequences(150);
    for (int i = 0; i < 8; i++) cfg_next[i] = post_seq_pkg::CFG_W'($urandom);
    program_registers();
    run_sequences(100);
    for (int i = 0; i < 7; i++) cfg_next[i] = post_seq_pkg::CFG_W'($urandom_range(0, 12));
    cfg_next[post_seq_pkg::CFG_IGNORE_MASK] = post_seq_pkg::CFG_W'($urandom);
    program_registers();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    run_sequences(100);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    for (int i = 0; i < 7; i++) cfg_next[i] = post_seq_pkg::CFG_W'($urandom_range(0, 600));
    cfg_next[post_seq_pkg::CFG_IGNORE_MASK] = $urandom_range(0, 1) ? 16'h00FF : 16'hFF00;
    program_registers();
    run_sequences(150);
  endtask

  initial begin
    reset_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_events();
    run_sequences(20);
    test_backpressure();
    test_register_extremes();
    test_random_settings();
    quiesce();
    if (failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
